// ===== rtl/core/positional_list_store_assert.svh =====
// assertion macros for the positional list store
// no dependencies; included by modules that carry assertions
`ifndef POSITIONAL_LIST_STORE_ASSERT_SVH
`define POSITIONAL_LIST_STORE_ASSERT_SVH

// same-cycle implication
`define PLS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define PLS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== rtl/core/pls_pkg.sv =====
// shared types and codes for the positional list store
// no dependencies
package pls_pkg;

	localparam logic [2:0] ACT_INS_FRONT = 3'd0;
	localparam logic [2:0] ACT_INS_BACK  = 3'd1;
	localparam logic [2:0] ACT_INS_POS   = 3'd2;
	localparam logic [2:0] ACT_DEL_FRONT = 3'd3;
	localparam logic [2:0] ACT_DEL_BACK  = 3'd4;
	localparam logic [2:0] ACT_DEL_POS   = 3'd5;
	localparam logic [2:0] ACT_DISPLAY   = 3'd6;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_INVALID = 2'd1;
	localparam logic [1:0] STAT_FULL    = 2'd2;
	localparam logic [1:0] STAT_EMPTY   = 2'd3;

	typedef struct packed {
		logic        [2:0]  action;
		logic signed [31:0] value;
		logic        [7:0]  position;
	} req_t;

	typedef struct packed {
		logic        [1:0]  status;
		logic        [4:0]  element_count;
		logic signed [31:0] element_value;
		logic               last_result;
	} result_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic step;
	} ctrl_cmd_t;

	typedef struct packed {
		logic disp_go;
		logic disp_end;
	} dp_stat_t;

endpackage

// ===== rtl/core/positional_list_store.sv =====
// top level of the positional list store: controller plus datapath
// depends on pls_pkg, pls_ctrl and pls_dp
//
// channel   ports                  handshake
// request   start, busy, request   taken at a clock edge with start high and busy low
// result    done, result           one cycle per result, done high, no back-pressure
//
// insert, delete and rejected requests register the request when accepted, then in the exec state
// shift the element array and load the result register
// display gives one result per element, rotating the array by one
// position a cycle so the front entry is always the one shown
// reset clears the count and control; element contents are undefined until written
// busy stays high from acceptance until the last result has been loaded
module positional_list_store #(
	parameter int CAPACITY    = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  pls_pkg::req_t     request,
	output logic              busy,
	output logic              done,
	output pls_pkg::result_t  result
);

	pls_pkg::ctrl_cmd_t cmd;
	pls_pkg::dp_stat_t  stat;

	pls_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	pls_dp #(
		.CAPACITY    (CAPACITY),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.stat    (stat),
		.result  (result),
		.done    (done)
	);

endmodule

// ===== rtl/core/pls_ctrl.sv =====
// controller state machine for the positional list store
// depends on pls_pkg
module pls_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  pls_pkg::dp_stat_t    stat,
	output logic                 busy,
	output pls_pkg::ctrl_cmd_t   cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_DISP = 3'b100
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec  = 1'b1;
				state_nxt = stat.disp_go ? ST_DISP : ST_IDLE;
			end
			ST_DISP: begin
				cmd.step = 1'b1;
				if (stat.disp_end) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ===== rtl/core/pls_dp.sv =====
// datapath of the positional list store: request register, shifting element array,
// count, display index and result register; depends on pls_pkg and the assert macros
`include "positional_list_store_assert.svh"

module pls_dp #(
	parameter int CAPACITY    = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pls_pkg::req_t        request,
	input  pls_pkg::ctrl_cmd_t   cmd,
	output pls_pkg::dp_stat_t    stat,
	output pls_pkg::result_t     result,
	output logic                 done
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);

	pls_pkg::req_t           req_q;
	logic [CW-1:0]           count_q;
	logic [IW-1:0]           disp_idx_q;
	logic [VALUE_WIDTH-1:0]  elem_q   [CAPACITY];
	logic [VALUE_WIDTH-1:0]  elem_nxt [CAPACITY];
	pls_pkg::result_t        result_q;
	logic                    done_q;

	logic                    full_w;
	logic                    empty_w;
	logic                    ins_w;
	logic                    del_w;
	logic [1:0]              status_w;
	logic [8:0]              cnt_ext_w;
	logic [8:0]              pos_ext_w;
	logic [8:0]              idx9_w;
	logic [IW-1:0]           idx_w;
	logic [CW-1:0]           cnt_nxt_w;
	logic [VALUE_WIDTH-1:0]  in_val_w;
	logic                    disp_end_w;

	assign full_w    = (count_q == CW'(CAPACITY));
	assign empty_w   = (count_q == '0);
	assign cnt_ext_w = 9'(count_q);
	assign pos_ext_w = {1'b0, req_q.position};
	assign in_val_w  = VALUE_WIDTH'($unsigned(req_q.value));
	assign idx_w     = IW'(idx9_w);

	// command decode
	always_comb begin
		ins_w    = 1'b0;
		del_w    = 1'b0;
		status_w = pls_pkg::STAT_OK;
		idx9_w   = '0;
		case (req_q.action)
			pls_pkg::ACT_INS_FRONT: begin
				if (full_w) status_w = pls_pkg::STAT_FULL;
				else ins_w = 1'b1;
			end
			pls_pkg::ACT_INS_BACK: begin
				idx9_w = cnt_ext_w;
				if (full_w) status_w = pls_pkg::STAT_FULL;
				else ins_w = 1'b1;
			end
			pls_pkg::ACT_INS_POS: begin
				idx9_w = pos_ext_w - 9'd1;
				if (full_w) status_w = pls_pkg::STAT_FULL;
				else if (pos_ext_w == 9'd0 || pos_ext_w > cnt_ext_w + 9'd1)
					status_w = pls_pkg::STAT_INVALID;
				else ins_w = 1'b1;
			end
			pls_pkg::ACT_DEL_FRONT: begin
				if (empty_w) status_w = pls_pkg::STAT_EMPTY;
				else del_w = 1'b1;
			end
			pls_pkg::ACT_DEL_BACK: begin
				idx9_w = cnt_ext_w - 9'd1;
				if (empty_w) status_w = pls_pkg::STAT_EMPTY;
				else del_w = 1'b1;
			end
			pls_pkg::ACT_DEL_POS: begin
				idx9_w = pos_ext_w - 9'd1;
				if (empty_w) status_w = pls_pkg::STAT_EMPTY;
				else if (pos_ext_w == 9'd0 || pos_ext_w > cnt_ext_w)
					status_w = pls_pkg::STAT_INVALID;
				else del_w = 1'b1;
			end
			pls_pkg::ACT_DISPLAY: begin
				if (empty_w) status_w = pls_pkg::STAT_EMPTY;
			end
			default: begin
				status_w = pls_pkg::STAT_INVALID;
			end
		endcase
	end

	always_comb begin
		cnt_nxt_w = count_q;
		if (ins_w) cnt_nxt_w = count_q + CW'(1);
		else if (del_w) cnt_nxt_w = count_q - CW'(1);
	end

	assign disp_end_w    = ((CW'(disp_idx_q) + CW'(1)) == count_q);
	assign stat.disp_go  = (req_q.action == pls_pkg::ACT_DISPLAY) && !empty_w;
	assign stat.disp_end = disp_end_w;

	// per-entry next value: insert shifts up, delete shifts down, display rotates
	for (genvar g = 0; g < CAPACITY; g++) begin : g_entry
		logic [VALUE_WIDTH-1:0] prev_w;
		logic [VALUE_WIDTH-1:0] next_w;

		if (g > 0) begin : g_prev
			assign prev_w = elem_q[g-1];
		end else begin : g_noprev
			assign prev_w = elem_q[g];
		end

		if (g < CAPACITY - 1) begin : g_next
			assign next_w = elem_q[g+1];
		end else begin : g_nonext
			assign next_w = elem_q[g];
		end

		always_comb begin
			elem_nxt[g] = elem_q[g];
			if (cmd.exec && ins_w) begin
				if (IW'(g) == idx_w) elem_nxt[g] = in_val_w;
				else if (IW'(g) > idx_w) elem_nxt[g] = prev_w;
			end else if (cmd.exec && del_w) begin
				if (IW'(g) >= idx_w) elem_nxt[g] = next_w;
			end else if (cmd.step) begin
				if (CW'(g) + CW'(1) < count_q) elem_nxt[g] = next_w;
				else if (CW'(g) + CW'(1) == count_q) elem_nxt[g] = elem_q[0];
			end
		end
	end

	always_ff @(posedge clk) begin
		elem_q <= elem_nxt;
		if (cmd.load) begin
			req_q <= request;
		end
		if (cmd.exec) begin
			result_q.status        <= status_w;
			result_q.element_count <= 5'(cnt_nxt_w);
			result_q.element_value <= '0;
			result_q.last_result   <= 1'b1;
		end else if (cmd.step) begin
			result_q.status        <= pls_pkg::STAT_OK;
			result_q.element_count <= 5'(count_q);
			result_q.element_value <= $signed(32'(elem_q[0]));
			result_q.last_result   <= disp_end_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			disp_idx_q <= '0;
			done_q     <= 1'b0;
		end else begin
			if (cmd.exec) begin
				count_q <= cnt_nxt_w;
			end
			if (cmd.exec) begin
				disp_idx_q <= '0;
			end else if (cmd.step) begin
				disp_idx_q <= disp_idx_q + IW'(1);
			end
			done_q <= (cmd.exec && !stat.disp_go) || cmd.step;
		end
	end

	assign result = result_q;
	assign done   = done_q;

	`PLS_ASSERT_NOW(a_count_range, clk, arst_n, 1'b1, count_q <= CW'(CAPACITY), "count above capacity")
	`PLS_ASSERT_NEXT(a_ins_grows, clk, arst_n, cmd.exec && ins_w, count_q == $past(count_q) + CW'(1), "insert did not grow count")
	`PLS_ASSERT_NEXT(a_del_shrinks, clk, arst_n, cmd.exec && del_w, count_q == $past(count_q) - CW'(1), "delete did not shrink count")
	`PLS_ASSERT_NEXT(a_reject_holds, clk, arst_n, cmd.exec && (status_w != pls_pkg::STAT_OK), $stable(count_q) && done_q, "rejected request changed count or gave no result")

endmodule

// ===== sim/positional_list_store_test.sv =====
// self-checking testbench for the positional list store: directed and random requests
// with an in-bench model of the list; depends on pls_pkg and positional_list_store
module positional_list_store_test;

	localparam int CAPACITY = 16;
	localparam logic [2:0] ACT_UNUSED = 3'd7;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_COMMANDS = 405;
	localparam int SETTLE_CYCLES = 40;
	localparam int CALM_TAIL = 50;

	typedef struct {
		pls_pkg::req_t cmd;
		bit            drain;
	} pending_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	pls_pkg::req_t request = '0;
	logic busy;
	logic done;
	pls_pkg::result_t result;

	pending_t command_queue[$];
	pls_pkg::result_t expected_results[$];

	logic signed [31:0] list_model [CAPACITY];
	int list_len = 0;
	int gen_len = 0;
	int gap_left = 0;
	int mismatches = 0;
	int commands_sent = 0;
	int results_checked = 0;
	int full_rejects = 0;
	int empty_rejects = 0;
	int invalid_rejects = 0;
	int displays = 0;
	int cycles = 0;

	positional_list_store uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.request(request),
		.busy(busy),
		.done(done),
		.result(result)
	);

	always #5 clk = ~clk;

	function automatic int len_after(pls_pkg::req_t c, int len);
		if (c.action <= pls_pkg::ACT_INS_POS) begin
			if (len < CAPACITY && (c.action != pls_pkg::ACT_INS_POS ||
					(c.position >= 1 && c.position <= len + 1)))
				return len + 1;
		end else if (c.action <= pls_pkg::ACT_DEL_POS) begin
			if (len > 0 && (c.action != pls_pkg::ACT_DEL_POS ||
					(c.position >= 1 && c.position <= len)))
				return len - 1;
		end
		return len;
	endfunction

	task automatic add_command(logic [2:0] act, logic signed [31:0] val, logic [7:0] pos,
			bit drain);
		pending_t p;
		p.cmd.action = act;
		p.cmd.value = val;
		p.cmd.position = pos;
		p.drain = drain;
		command_queue.push_back(p);
		gen_len = len_after(p.cmd, gen_len);
	endtask

	task automatic apply_command(pls_pkg::req_t cmd);
		pls_pkg::result_t res;
		int idx;
		res = '0;
		idx = -1;
		if (cmd.action == pls_pkg::ACT_DISPLAY) begin
			displays++;
			if (list_len == 0) begin
				res.status = pls_pkg::STAT_EMPTY;
				res.last_result = 1'b1;
				expected_results.push_back(res);
			end else begin
				for (int i = 0; i < list_len; i++) begin
					res.status = pls_pkg::STAT_OK;
					res.element_count = 5'(list_len);
					res.element_value = list_model[i];
					res.last_result = (i == list_len - 1);
					expected_results.push_back(res);
				end
			end
		end else begin
			res.status = pls_pkg::STAT_OK;
			if (cmd.action <= pls_pkg::ACT_INS_POS) begin
				if (list_len >= CAPACITY)
					res.status = pls_pkg::STAT_FULL;
				else if (cmd.action == pls_pkg::ACT_INS_FRONT)
					idx = 0;
				else if (cmd.action == pls_pkg::ACT_INS_BACK)
					idx = list_len;
				else if (cmd.position < 1 || cmd.position > list_len + 1)
					res.status = pls_pkg::STAT_INVALID;
				else
					idx = cmd.position - 1;
				if (idx >= 0) begin
					for (int i = list_len; i > idx; i--)
						list_model[i] = list_model[i - 1];
					list_model[idx] = cmd.value;
					list_len++;
				end
			end else if (cmd.action <= pls_pkg::ACT_DEL_POS) begin
				if (list_len == 0)
					res.status = pls_pkg::STAT_EMPTY;
				else if (cmd.action == pls_pkg::ACT_DEL_FRONT)
					idx = 0;
				else if (cmd.action == pls_pkg::ACT_DEL_BACK)
					idx = list_len - 1;
				else if (cmd.position < 1 || cmd.position > list_len)
					res.status = pls_pkg::STAT_INVALID;
				else
					idx = cmd.position - 1;
				if (idx >= 0) begin
					for (int i = idx; i + 1 < list_len; i++)
						list_model[i] = list_model[i + 1];
					list_len--;
				end
			end else begin
				res.status = pls_pkg::STAT_INVALID;
			end
			case (res.status)
				pls_pkg::STAT_FULL: full_rejects++;
				pls_pkg::STAT_EMPTY: empty_rejects++;
				pls_pkg::STAT_INVALID: invalid_rejects++;
				default: ;
			endcase
			res.element_count = 5'(list_len);
			res.last_result = 1'b1;
			expected_results.push_back(res);
		end
	endtask

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : drive_requests
		bit taken;
		bit present;
		if (!arst_n) begin
			start <= 1'b0;
			gap_left = 0;
		end else begin
			taken = start && !busy;
			if (taken) begin
				apply_command(command_queue[0].cmd);
				command_queue.delete(0);
				commands_sent++;
				if (command_queue.size() > CALM_TAIL && $urandom_range(0, 99) < 30)
					gap_left = $urandom_range(1, 9);
			end
			if (!start || taken) begin
				present = 1'b0;
				if (gap_left > 0)
					gap_left--;
				else if (command_queue.size() != 0 &&
						!(command_queue[0].drain && expected_results.size() != 0))
					present = 1'b1;
				start <= present;
				if (present)
					request <= command_queue[0].cmd;
			end
		end
	end

	always @(posedge clk) begin : watch_results
		pls_pkg::result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %0h", $time, result);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				check_field("status", 32'(want.status), 32'(result.status));
				check_field("element_count", 32'(want.element_count),
					32'(result.element_count));
				check_field("element_value", want.element_value, result.element_value);
				check_field("last_result", 32'(want.last_result), 32'(result.last_result));
			end
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin
		logic signed [31:0] corner_values [4];
		int ins_weight [4];
		int mode;
		int r;
		logic [2:0] act;
		logic [7:0] pos;
		logic signed [31:0] val;

		corner_values = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, -32'sd1};
		ins_weight = '{64, 22, 43, 85};

		// directed: empty store, bad positions, extremes, shifts, unused code
		add_command(pls_pkg::ACT_DISPLAY, 0, 0, 1'b0);
		add_command(pls_pkg::ACT_DEL_FRONT, 0, 0, 1'b0);
		add_command(pls_pkg::ACT_DEL_BACK, 0, 0, 1'b0);
		add_command(pls_pkg::ACT_DEL_POS, 0, 0, 1'b0);
		add_command(pls_pkg::ACT_INS_POS, 32'sh1234_5678, 0, 1'b0);
		add_command(pls_pkg::ACT_INS_POS, 32'sh1234_5678, 2, 1'b0);
		add_command(pls_pkg::ACT_INS_POS, 32'sh8000_0000, 1, 1'b0);
		add_command(pls_pkg::ACT_INS_FRONT, 32'sh7fff_ffff, 8'hff, 1'b0);
		add_command(pls_pkg::ACT_INS_BACK, 32'sh0, 8'hff, 1'b0);
		add_command(pls_pkg::ACT_INS_BACK, -32'sd1, 0, 1'b0);
		add_command(pls_pkg::ACT_INS_POS, 32'sh5a5a_5a5a, 3, 1'b0);
		add_command(pls_pkg::ACT_INS_POS, 32'sha5a5_a5a5, 6, 1'b0);
		add_command(pls_pkg::ACT_INS_POS, 32'sh0f0f_0f0f, 8'hff, 1'b0);
		add_command(pls_pkg::ACT_DISPLAY, -32'sd1, 8'hff, 1'b0);
		add_command(pls_pkg::ACT_DEL_POS, 0, 0, 1'b0);
		add_command(pls_pkg::ACT_DEL_POS, 0, 7, 1'b0);
		add_command(pls_pkg::ACT_DEL_POS, 0, 8'hff, 1'b0);
		add_command(pls_pkg::ACT_DEL_POS, 0, 6, 1'b0);
		add_command(pls_pkg::ACT_DEL_POS, 0, 1, 1'b0);
		add_command(pls_pkg::ACT_DEL_POS, 0, 2, 1'b0);
		add_command(pls_pkg::ACT_DEL_FRONT, -32'sd1, 8'hff, 1'b0);
		add_command(pls_pkg::ACT_DEL_BACK, 0, 0, 1'b0);
		add_command(ACT_UNUSED, -32'sd1, 8'hff, 1'b0);
		add_command(pls_pkg::ACT_DISPLAY, 0, 0, 1'b0);
		add_command(pls_pkg::ACT_DEL_BACK, 0, 0, 1'b0);

		mode = 3;
		for (int n = 0; n < RANDOM_COMMANDS; n++) begin
			if (n != 0 && n % 24 == 0)
				mode = $urandom_range(0, 3);
			r = $urandom_range(0, 99);
			if (r < ins_weight[mode])
				act = 3'($urandom_range(pls_pkg::ACT_INS_FRONT, pls_pkg::ACT_INS_POS));
			else if (r < 86)
				act = 3'($urandom_range(pls_pkg::ACT_DEL_FRONT, pls_pkg::ACT_DEL_POS));
			else if (r < 98)
				act = pls_pkg::ACT_DISPLAY;
			else
				act = ACT_UNUSED;
			pos = 8'($urandom_range(0, 255));
			if ((act == pls_pkg::ACT_INS_POS || act == pls_pkg::ACT_DEL_POS) &&
					$urandom_range(0, 99) < 85) begin
				if (act == pls_pkg::ACT_INS_POS)
					pos = 8'($urandom_range(1, gen_len + 1));
				else if (gen_len > 0)
					pos = 8'($urandom_range(1, gen_len));
			end
			val = ($urandom_range(0, 4) == 0) ? corner_values[2'($urandom_range(0, 3))] :
				$urandom;
			add_command(act, val, pos, n == 0 || n == 215);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		while (command_queue.size() != 0 || start)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("ran %0d requests, %0d results checked, %0d displays", commands_sent,
			results_checked, displays);
		$display("rejections: %0d full, %0d empty, %0d invalid position or code",
			full_rejects, empty_rejects, invalid_rejects);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== positional_list_store.f =====
+incdir+rtl/core
rtl/core/pls_pkg.sv
rtl/core/pls_ctrl.sv
rtl/core/pls_dp.sv
rtl/core/positional_list_store.sv
sim/positional_list_store_test.sv
